// ===== rtl/tds_pkg.sv =====
package tds_pkg;

    // Filter word: 40-bit two's complement, FRAC_BITS fraction bits
    localparam int FRAC_BITS = 16;
    localparam int FILT_W    = 40;
    // Integer part of the filter word after truncation
    localparam int INT_W     = FILT_W - FRAC_BITS;
    // Smoothing weight is a fraction over 2**SMOOTH_W
    localparam int SMOOTH_W  = 16;

    localparam int POS_W     = 16;
    localparam int LEVEL_W   = 16;
    localparam int MOVE_W    = 16;
    localparam int INFO_W    = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0]  THRESHOLD_RST = 16'd100;
    localparam logic [SMOOTH_W-1:0] SMOOTHING_RST = 16'd32768;
    localparam logic [INFO_W-1:0]   NOISE_RST     = 8'h08;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_SMOOTHING  = 2'd1,
        CFG_NOISE_MASK = 2'd2
    } cfg_reg_t;

    localparam logic signed [MOVE_W-1:0] MOVE_MAX = 16'sh7FFF;
    localparam logic signed [MOVE_W-1:0] MOVE_MIN = 16'sh8000;

    // Clamp a widened integer part to the 16-bit result range
    function automatic logic signed [MOVE_W-1:0] sat_move(input logic signed [INT_W:0] v);
        logic signed [INT_W:0] hi;
        logic signed [INT_W:0] lo;
        hi = (INT_W+1)'(MOVE_MAX);
        lo = (INT_W+1)'(MOVE_MIN);
        if (v > hi)
            sat_move = MOVE_MAX;
        else if (v < lo)
            sat_move = MOVE_MIN;
        else
            sat_move = v[MOVE_W-1:0];
    endfunction

endpackage

// ===== rtl/tds_axis_filter.sv =====
// One axis: position delta, smoothing step and truncated integer part.
module tds_axis_filter
    import tds_pkg::*;
(
    input  logic [POS_W-1:0]         pos,
    input  logic [POS_W-1:0]         last,
    input  logic signed [FILT_W-1:0] filt,
    input  logic [SMOOTH_W-1:0]      smoothing,
    output logic signed [FILT_W-1:0] filt_next,
    output logic signed [INT_W-1:0]  int_part
);

    logic [POS_W-1:0]                   delta;
    logic signed [FILT_W:0]             delta_fix;
    logic signed [FILT_W:0]             diff;
    logic signed [FILT_W+SMOOTH_W+1:0]  prod;
    logic signed [FILT_W:0]             sum;
    logic signed [INT_W-1:0]            floor_int;
    logic                               round_up;

    // f' = D + floor(a * (f - D) / 2**16), D = delta << FRAC_BITS
    assign delta     = pos - last;
    assign delta_fix = $signed({{(FILT_W+1-POS_W-FRAC_BITS){delta[POS_W-1]}},
                                delta, {FRAC_BITS{1'b0}}});
    assign diff      = $signed({filt[FILT_W-1], filt}) - delta_fix;
    assign prod      = $signed({1'b0, smoothing}) * diff;
    assign sum       = delta_fix + $signed(prod[SMOOTH_W +: FILT_W+1]);
    assign filt_next = sum[FILT_W-1:0];

    // Truncate the updated value toward zero: floor, plus one for a negative
    // value with a fraction
    assign floor_int = filt_next[FILT_W-1:FRAC_BITS];
    assign round_up  = filt_next[FILT_W-1] & (|filt_next[FRAC_BITS-1:0]);
    assign int_part  = floor_int + $signed({{(INT_W-1){1'b0}}, round_up});

endmodule

// ===== rtl/touch_delta_smoother.sv =====
// An accepted report waits in the input register; its result then moves on to the output
// register when that is free, and leaves from there once out_ready is high.
// Throughput: one report per cycle; a stalled result holds the input stage, and with
// both stages full in_ready follows out_ready in the same cycle.
// Noisy reports in the pressed state are dropped and free the input stage silently.
// Reset (rst_n low, asynchronous): pad released, stored position and filters zero,
// registers back to threshold 100, smoothing 32768, noise mask 0x08; both stages empty.
module touch_delta_smoother
    import tds_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration writes
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    // report channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [INFO_W-1:0]        info_byte,
    input  logic [POS_W-1:0]         pos_x,
    input  logic [POS_W-1:0]         pos_y,
    input  logic [LEVEL_W-1:0]       touch_level,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [MOVE_W-1:0] move_x,
    output logic signed [MOVE_W-1:0] move_y,
    output logic [LEVEL_W-1:0]       level_echo,
    output logic                     moving
);

    // configuration registers
    logic [LEVEL_W-1:0]  threshold_reg;
    logic [SMOOTH_W-1:0] smoothing_reg;
    logic [INFO_W-1:0]   noise_mask_reg;

    // input stage
    logic                in_valid_reg;
    logic [INFO_W-1:0]   info_reg;
    logic [POS_W-1:0]    px_reg;
    logic [POS_W-1:0]    py_reg;
    logic [LEVEL_W-1:0]  lvl_reg;

    // tracking state
    logic                pressed_reg, pressed_next;
    logic [POS_W-1:0]    last_x_reg, last_x_next;
    logic [POS_W-1:0]    last_y_reg, last_y_next;
    logic signed [FILT_W-1:0] filt_x_reg, filt_x_next;
    logic signed [FILT_W-1:0] filt_y_reg, filt_y_next;

    // output stage
    logic                     out_valid_reg, out_valid_next;
    logic signed [MOVE_W-1:0] move_x_reg, move_x_next;
    logic signed [MOVE_W-1:0] move_y_reg, move_y_next;
    logic [LEVEL_W-1:0]       level_reg;
    logic                     moving_reg, moving_next;

    logic out_free;
    logic advance;
    logic emit;

    logic signed [FILT_W-1:0] step_x, step_y;
    logic signed [INT_W-1:0]  int_x, int_y;

    // Output slot is free when empty or being drained this cycle; the input
    // stage hands its report on whenever the slot is free.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    // configuration, taken at any edge with the write enable high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RST;
            smoothing_reg  <= SMOOTHING_RST;
            noise_mask_reg <= NOISE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_THRESHOLD:  threshold_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_SMOOTHING:  smoothing_reg  <= cfg_data[SMOOTH_W-1:0];
                CFG_NOISE_MASK: noise_mask_reg <= cfg_data[INFO_W-1:0];
                default:        ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            info_reg <= info_byte;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            lvl_reg  <= touch_level;
        end
    end

    // both axes filtered in parallel, one multiply each
    tds_axis_filter u_filt_x (
        .pos       (px_reg),
        .last      (last_x_reg),
        .filt      (filt_x_reg),
        .smoothing (smoothing_reg),
        .filt_next (step_x),
        .int_part  (int_x)
    );

    tds_axis_filter u_filt_y (
        .pos       (py_reg),
        .last      (last_y_reg),
        .filt      (filt_y_reg),
        .smoothing (smoothing_reg),
        .filt_next (step_y),
        .int_part  (int_y)
    );

    // report decision
    always_comb
    begin
        pressed_next = pressed_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        filt_x_next  = filt_x_reg;
        filt_y_next  = filt_y_reg;
        emit         = 1'b1;
        moving_next  = 1'b0;
        move_x_next  = '0;
        move_y_next  = '0;

        if (!pressed_reg)
        begin
            // released: always a zero result; press needs both coords and strength
            if (px_reg != '0 && py_reg != '0 && lvl_reg > threshold_reg)
            begin
                pressed_next = 1'b1;
                last_x_next  = px_reg;
                last_y_next  = py_reg;
            end
        end
        else if (lvl_reg < threshold_reg)
        begin
            // lift-off
            pressed_next = 1'b0;
            last_x_next  = '0;
            last_y_next  = '0;
        end
        else if ((info_reg & noise_mask_reg) != '0)
        begin
            // noisy report: no result, no state change
            emit = 1'b0;
        end
        else
        begin
            // movement; filter state deliberately survives across presses
            filt_x_next = step_x;
            filt_y_next = step_y;
            last_x_next = px_reg;
            last_y_next = py_reg;
            moving_next = 1'b1;
            move_x_next = sat_move({int_x[INT_W-1], int_x});
            move_y_next = sat_move(-$signed({int_y[INT_W-1], int_y}));
        end
    end

    // tracking state moves on only when the report leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            filt_x_reg  <= '0;
            filt_y_reg  <= '0;
        end
        else if (advance)
        begin
            pressed_reg <= pressed_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            filt_x_reg  <= filt_x_next;
            filt_y_reg  <= filt_y_next;
        end
    end

    // output register
    assign out_valid_next = advance ? emit : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            move_x_reg <= move_x_next;
            move_y_reg <= move_y_next;
            level_reg  <= lvl_reg;
            moving_reg <= moving_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign move_x     = move_x_reg;
    assign move_y     = move_y_reg;
    assign level_echo = level_reg;
    assign moving     = moving_reg;

endmodule

// ===== rtl/tds_checker.sv =====
// Port-level checks for the touch smoother.
module tds_checker
    import tds_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [MOVE_W-1:0] move_x,
    input logic signed [MOVE_W-1:0] move_y,
    input logic [LEVEL_W-1:0]       level_echo,
    input logic                     moving
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(move_x) && $stable(move_y)
            && $stable(level_echo) && $stable(moving))
        else $error("result changed while stalled");

    // idle and release results carry no movement
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !moving |-> move_x == '0 && move_y == '0)
        else $error("nonzero movement in idle result");

    // a fresh result follows an earlier input transfer through the input and output registers
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching input transfer");

    // an empty output never holds back the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output empty");

endmodule

bind touch_delta_smoother tds_checker u_tds_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .move_x     (move_x),
    .move_y     (move_y),
    .level_echo (level_echo),
    .moving     (moving)
);

// ===== dv/tb_touch_delta_smoother.sv =====
`timescale 1ns / 100ps

module tb_touch_delta_smoother;
    import tds_pkg::*;

    // cycles without any transfer or register write before the run is declared hung
    localparam int unsigned HANG_LIMIT    = 2000;
    // output stage depth plus margin; a dropped noisy report leaves no trace
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RAND_PHASES   = 8;
    localparam int unsigned PHASE_ITEMS   = 125;

    typedef struct {
        logic signed [MOVE_W-1:0] mx;
        logic signed [MOVE_W-1:0] my;
        logic [LEVEL_W-1:0]       echo;
        logic                     mv;
    } move_rec_t;

    // how a directed row is handled
    typedef enum logic [1:0] {
        ROW_TYPED,      // expected result written in the row
        ROW_CHECKED,    // expected result from the predictor
        ROW_SILENT,     // no result may come back
        ROW_WRITE       // register write between transfers
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        cfg_reg_t           sel;
        logic [CFG_W-1:0]   wdata;
        logic [INFO_W-1:0]  info;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [LEVEL_W-1:0] lvl;
        move_rec_t          want;
    } row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [INFO_W-1:0]        info_byte = '0;
    logic [POS_W-1:0]         pos_x = '0;
    logic [POS_W-1:0]         pos_y = '0;
    logic [LEVEL_W-1:0]       touch_level = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
    logic [LEVEL_W-1:0]       level_echo;
    logic                     moving;

    touch_delta_smoother uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .info_byte   (info_byte),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .touch_level (touch_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .move_x      (move_x),
        .move_y      (move_y),
        .level_echo  (level_echo),
        .moving      (moving)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: pad state, stored position, filters and register copies
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0]       thr_cfg    = THRESHOLD_RST;
    logic [SMOOTH_W-1:0]      smooth_cfg = SMOOTHING_RST;
    logic [INFO_W-1:0]        nmask_cfg  = NOISE_RST;
    logic                     pad_down   = 1'b0;
    logic [POS_W-1:0]         last_x     = '0;
    logic [POS_W-1:0]         last_y     = '0;
    logic signed [FILT_W-1:0] filt_x     = '0;
    logic signed [FILT_W-1:0] filt_y     = '0;

    move_rec_t   pending_moves[$];
    int unsigned err_count = 0;

    // one EMA step: new = floor((a*old + (2^16-a)*(d << FRAC_BITS)) / 2^16), kept to 40 bits
    function automatic logic signed [FILT_W-1:0] ema_step(
        input logic signed [FILT_W-1:0] f,
        input logic signed [POS_W-1:0]  d
    );
        longint weight_new;
        longint acc;
        weight_new = (longint'(1) <<< SMOOTH_W) - longint'(smooth_cfg);
        acc = longint'(smooth_cfg) * longint'(f) + weight_new * (longint'(d) <<< FRAC_BITS);
        acc = acc >>> SMOOTH_W;     // arithmetic shift is the floor
        return acc[FILT_W-1:0];
    endfunction

    // integer part, truncated toward zero
    function automatic longint int_part(input logic signed [FILT_W-1:0] f);
        longint v;
        v = f;
        if (v < 0)
            return -((-v) >>> FRAC_BITS);
        return v >>> FRAC_BITS;
    endfunction

    function automatic logic signed [MOVE_W-1:0] clamp_move(input longint v);
        if (v > longint'(MOVE_MAX))
            return MOVE_MAX;
        if (v < longint'(MOVE_MIN))
            return MOVE_MIN;
        return v[MOVE_W-1:0];
    endfunction

    // Advances the predicted pad state by one report; returns 1 when a result is due.
    function automatic bit smooth_report(
        input  logic [INFO_W-1:0]  info,
        input  logic [POS_W-1:0]   x,
        input  logic [POS_W-1:0]   y,
        input  logic [LEVEL_W-1:0] lvl,
        output move_rec_t          rec
    );
        logic signed [POS_W-1:0] dx;
        logic signed [POS_W-1:0] dy;
        rec = '{mx: '0, my: '0, echo: lvl, mv: 1'b0};
        // released: always a zero report; press needs both coordinates and a
        // strength strictly above threshold, noise bits ignored
        if (!pad_down) begin
            if (x != 0 && y != 0 && lvl > thr_cfg) begin
                pad_down = 1'b1;
                last_x   = x;
                last_y   = y;
            end
            return 1'b1;
        end
        // strictly below threshold releases; equal keeps the pad pressed
        if (lvl < thr_cfg) begin
            pad_down = 1'b0;
            last_x   = '0;
            last_y   = '0;
            return 1'b1;
        end
        if ((info & nmask_cfg) != 0)
            return 1'b0;
        dx = x - last_x;            // wraps modulo 2^16
        dy = y - last_y;
        filt_x = ema_step(filt_x, dx);
        filt_y = ema_step(filt_y, dy);
        rec.mx = clamp_move(int_part(filt_x));
        rec.my = clamp_move(-int_part(filt_y));
        rec.mv = 1'b1;
        last_x = x;
        last_y = y;
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic send_report(
        input logic [INFO_W-1:0]  info,
        input logic [POS_W-1:0]   x,
        input logic [POS_W-1:0]   y,
        input logic [LEVEL_W-1:0] lvl
    );
        int unsigned gap;
        if (burst_left == 0) begin
            // a quarter of bursts follow straight on, giving gap-free stretches
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        info_byte   <= info;
        pos_x       <= x;
        pos_y       <= y;
        touch_level <= lvl;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Register writes only with the block drained; a trailing noisy report
    // produces nothing, hence the extra settle cycles.
    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] data);
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        case (sel)
            CFG_THRESHOLD:  thr_cfg    = data;
            CFG_SMOOTHING:  smooth_cfg = data;
            CFG_NOISE_MASK: nmask_cfg  = data[INFO_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic row_t rpt_row(
        input row_kind_t                k,
        input logic [INFO_W-1:0]        info,
        input logic [POS_W-1:0]         x,
        input logic [POS_W-1:0]         y,
        input logic [LEVEL_W-1:0]       lvl,
        input logic signed [MOVE_W-1:0] wmx,
        input logic signed [MOVE_W-1:0] wmy,
        input logic                     wmv
    );
        row_t r;
        r.kind  = k;
        r.sel   = CFG_THRESHOLD;
        r.wdata = '0;
        r.info  = info;
        r.x     = x;
        r.y     = y;
        r.lvl   = lvl;
        r.want  = '{mx: wmx, my: wmy, echo: lvl, mv: wmv};
        return r;
    endfunction

    function automatic row_t wr_row(input cfg_reg_t sel, input logic [CFG_W-1:0] data);
        row_t r;
        r       = rpt_row(ROW_WRITE, '0, '0, '0, '0, '0, '0, 1'b0);
        r.sel   = sel;
        r.wdata = data;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: runs of random length, each ready or stall, ready two runs in three
    // ------------------------------------------------------------------
    int unsigned rx_run = 0;

    always @(posedge clk)
    begin
        if (rx_run == 0) begin
            rx_run    <= $urandom_range(1, 16);
            out_ready <= ($urandom_range(0, 2) != 0);
        end
        else begin
            rx_run <= rx_run - 1;
        end
    end

    // Result check: every output transfer against the oldest expectation
    always @(posedge clk)
    begin : result_check
        move_rec_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_moves.size() == 0) begin
                flag_error($sformatf("unexpected result x=%0d y=%0d echo=%0d moving=%0b",
                                     move_x, move_y, level_echo, moving));
            end
            else begin
                want = pending_moves.pop_front();
                if (move_x !== want.mx || move_y !== want.my ||
                    level_echo !== want.echo || moving !== want.mv)
                    flag_error($sformatf(
                        {"mismatch: exp x=%0d y=%0d echo=%0d moving=%0b, ",
                         "got x=%0d y=%0d echo=%0d moving=%0b"},
                        want.mx, want.my, want.echo, want.mv,
                        move_x, move_y, level_echo, moving));
            end
        end
    end

    // Watchdog: any transfer or write counts as progress
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= HANG_LIMIT) begin
            $display("tb_touch_delta_smoother failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        row_t               dir_rows[$];
        move_rec_t          rec;
        bit                 emits;
        logic [INFO_W-1:0]  info;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [LEVEL_W-1:0] lvl;
        logic [POS_W-1:0]   step;
        logic [CFG_W-1:0]   thr_new;
        logic [CFG_W-1:0]   smooth_new;
        logic [CFG_W-1:0]   mask_new;
        int unsigned        pick;

        // Directed part. Reset values: threshold 100, smoothing 1/2, noise mask 0x08.
        // released, no touch at all
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h0000, 16'h0000, 16'd0,    0, 0, 1'b0));
        // strength equal to threshold does not press
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h8000, 16'h1234, 16'd100,  0, 0, 1'b0));
        // one coordinate zero does not press
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h0005, 16'h0000, 16'hFFFF, 0, 0, 1'b0));
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h0000, 16'h0005, 16'hFFFF, 0, 0, 1'b0));
        // press at (0x1000, 0x1000)
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h1000, 16'h1000, 16'd101,  0, 0, 1'b0));
        // noisy report while pressed is dropped
        dir_rows.push_back(rpt_row(ROW_SILENT,  8'h08, 16'h1234, 16'h1234, 16'd500,  0, 0, 1'b0));
        // all other info bits set, strength equal to threshold: still a movement
        dir_rows.push_back(rpt_row(ROW_CHECKED, 8'hF7, 16'h1010, 16'h0FF0, 16'd100,  0, 0, 1'b0));
        dir_rows.push_back(rpt_row(ROW_CHECKED, 8'h00, 16'hFFFF, 16'h0001, 16'd200,  0, 0, 1'b0));
        dir_rows.push_back(rpt_row(ROW_CHECKED, 8'h00, 16'h7FFF, 16'h8001, 16'hFFFF, 0, 0, 1'b0));
        // just below threshold releases
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h0001, 16'h0001, 16'd99,   0, 0, 1'b0));
        // noise bits are ignored while released: this presses at the far corner
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1'b0));
        // no smoothing: filter equals the raw delta, results read straight off
        dir_rows.push_back(wr_row(CFG_SMOOTHING, 16'h0000));
        // dx = +5 across the wrap, dy = -32768 so the negated y saturates
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h0004, 16'h7FFF, 16'd300,
                                   16'sd5, 16'sh7FFF, 1'b1));
        // dx = +32767, dy = -32767
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h8003, 16'h0000, 16'd300,
                                   16'sh7FFF, 16'sh7FFF, 1'b1));
        // dx = -32768, dy = +1
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h0003, 16'h0001, 16'd300,
                                   16'sh8000, -16'sd1, 1'b1));
        // heaviest smoothing; filter state carried over
        dir_rows.push_back(wr_row(CFG_SMOOTHING, 16'hFFFF));
        dir_rows.push_back(rpt_row(ROW_CHECKED, 8'h00, 16'h0103, 16'h0101, 16'd1000, 0, 0, 1'b0));
        // threshold zero: nothing can release, zero strength still moves
        dir_rows.push_back(wr_row(CFG_THRESHOLD, 16'h0000));
        dir_rows.push_back(rpt_row(ROW_CHECKED, 8'h00, 16'h0203, 16'h0201, 16'd0,    0, 0, 1'b0));
        // threshold at top: release below it, and no press is possible
        dir_rows.push_back(wr_row(CFG_THRESHOLD, 16'hFFFF));
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h0300, 16'h0300, 16'hFFFE, 0, 0, 1'b0));
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h0001, 16'h0001, 16'hFFFF, 0, 0, 1'b0));
        // every info bit counts as noise
        dir_rows.push_back(wr_row(CFG_THRESHOLD, 16'h0000));
        dir_rows.push_back(wr_row(CFG_NOISE_MASK, 16'h00FF));
        dir_rows.push_back(rpt_row(ROW_TYPED,   8'h00, 16'h0001, 16'h0001, 16'd1,    0, 0, 1'b0));
        dir_rows.push_back(rpt_row(ROW_SILENT,  8'h01, 16'h0002, 16'h0002, 16'd5,    0, 0, 1'b0));
        dir_rows.push_back(rpt_row(ROW_CHECKED, 8'h00, 16'h0010, 16'h0020, 16'd5,    0, 0, 1'b0));
        // empty mask: nothing is noise
        dir_rows.push_back(wr_row(CFG_NOISE_MASK, 16'h0000));
        dir_rows.push_back(rpt_row(ROW_CHECKED, 8'hFF, 16'h0005, 16'hFFF0, 16'd7,    0, 0, 1'b0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                write_reg(dir_rows[i].sel, dir_rows[i].wdata);
            end
            else begin
                // the predictor runs on every row so its state tracks the block
                emits = smooth_report(dir_rows[i].info, dir_rows[i].x, dir_rows[i].y,
                                      dir_rows[i].lvl, rec);
                if (dir_rows[i].kind == ROW_TYPED)
                    pending_moves.push_back(dir_rows[i].want);
                else if (dir_rows[i].kind == ROW_CHECKED && emits)
                    pending_moves.push_back(rec);
                send_report(dir_rows[i].info, dir_rows[i].x, dir_rows[i].y, dir_rows[i].lvl);
            end
        end

        // Random part: one register setting per phase, extremes on fixed phases.
        // Mostly press / move / release sequences; a few fully random reports.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            thr_new = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
            if (ph == 3)
                thr_new = 16'h0000;
            else if (ph == 5)
                thr_new = 16'hFFFF;
            smooth_new = (ph == 1) ? 16'h0000 : (ph == 2) ? 16'hFFFF : 16'($urandom);
            mask_new = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                   : 16'(1 << $urandom_range(0, 7));
            if (ph == 4)
                mask_new = 16'h0000;
            else if (ph == 6)
                mask_new = 16'h00FF;
            write_reg(CFG_THRESHOLD, thr_new);
            write_reg(CFG_SMOOTHING, smooth_new);
            write_reg(CFG_NOISE_MASK, mask_new);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                info = INFO_W'($urandom);
                x    = POS_W'($urandom);
                y    = POS_W'($urandom);
                lvl  = LEVEL_W'($urandom);
                if (pick >= 8) begin
                    if (!pad_down) begin
                        // press attempt; some fall short of the threshold
                        x = POS_W'($urandom_range(1, 65535));
                        y = POS_W'($urandom_range(1, 65535));
                        if (pick >= 20 && thr_cfg != 16'hFFFF)
                            lvl = LEVEL_W'($urandom_range(int'(thr_cfg) + 1, 65535));
                    end
                    else if (pick < 16 && thr_cfg != 0) begin
                        lvl = LEVEL_W'($urandom_range(0, int'(thr_cfg) - 1));
                    end
                    else begin
                        // movement: mostly small steps around the stored position
                        lvl = LEVEL_W'($urandom_range(int'(thr_cfg), 65535));
                        if (pick < 90) begin
                            step = POS_W'($urandom_range(0, 600) - 300);
                            x    = last_x + step;
                            step = POS_W'($urandom_range(0, 600) - 300);
                            y    = last_y + step;
                        end
                        if (pick >= 24)
                            info = info & ~nmask_cfg;
                    end
                end
                emits = smooth_report(info, x, y, lvl, rec);
                if (emits)
                    pending_moves.push_back(rec);
                send_report(info, x, y, lvl);
            end
        end

        in_valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("tb_touch_delta_smoother passed");
        else
            $display("tb_touch_delta_smoother failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tds_pkg.sv
rtl/tds_axis_filter.sv
rtl/touch_delta_smoother.sv
rtl/tds_checker.sv
dv/tb_touch_delta_smoother.sv
